@@ hw/rtl/aicp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_pkg
// Shared types and codes of the A64 instruction class profiler.
// ----------------------------------------------------------------------------
package aicp_pkg;

	// request kinds
	localparam logic REQ_CLASSIFY = 1'b0;
	localparam logic REQ_READ     = 1'b1;

	// fixed field widths
	localparam int INSN_W  = 32;
	localparam int IDX_W   = 6;
	localparam int TOP_W   = 3;
	localparam int SUB_W   = 5;
	localparam int FORM_W  = 5;
	localparam int VALUE_W = 48;

	// histogram sizes and counter index map
	localparam int N_TOP  = 6;
	localparam int N_SUB  = 27;
	localparam int N_LDST = 17;
	localparam logic [IDX_W-1:0] SUB_BASE  = IDX_W'(N_TOP);
	localparam logic [IDX_W-1:0] LDST_BASE = IDX_W'(N_TOP + N_SUB);
	localparam logic [IDX_W-1:0] IDX_END   = IDX_W'(N_TOP + N_SUB + N_LDST);

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// top group codes
	localparam logic [TOP_W-1:0] TOP_DP_IMM  = 3'd0;
	localparam logic [TOP_W-1:0] TOP_BRANCH  = 3'd1;
	localparam logic [TOP_W-1:0] TOP_LDST    = 3'd2;
	localparam logic [TOP_W-1:0] TOP_DP_REG  = 3'd3;
	localparam logic [TOP_W-1:0] TOP_SIMD_FP = 3'd4;
	localparam logic [TOP_W-1:0] TOP_UNALLOC = 3'd5;

	// subgroup codes
	localparam logic [SUB_W-1:0] SUB_PC_REL      = 5'd0;
	localparam logic [SUB_W-1:0] SUB_ADDSUB_IMM  = 5'd1;
	localparam logic [SUB_W-1:0] SUB_LOGIC_IMM   = 5'd2;
	localparam logic [SUB_W-1:0] SUB_MOVE_WIDE   = 5'd3;
	localparam logic [SUB_W-1:0] SUB_BITFIELD    = 5'd4;
	localparam logic [SUB_W-1:0] SUB_EXTRACT     = 5'd5;
	localparam logic [SUB_W-1:0] SUB_UNCOND_IMM  = 5'd6;
	localparam logic [SUB_W-1:0] SUB_CMP_BRANCH  = 5'd7;
	localparam logic [SUB_W-1:0] SUB_TST_BRANCH  = 5'd8;
	localparam logic [SUB_W-1:0] SUB_COND_BRANCH = 5'd9;
	localparam logic [SUB_W-1:0] SUB_SYS_HINT    = 5'd10;
	localparam logic [SUB_W-1:0] SUB_SYS_BARRIER = 5'd11;
	localparam logic [SUB_W-1:0] SUB_SYS_MSR_IMM = 5'd12;
	localparam logic [SUB_W-1:0] SUB_SYS_OTHER   = 5'd13;
	localparam logic [SUB_W-1:0] SUB_EXCEPTION   = 5'd14;
	localparam logic [SUB_W-1:0] SUB_UNCOND_REG  = 5'd15;
	localparam logic [SUB_W-1:0] SUB_LDST        = 5'd16;
	localparam logic [SUB_W-1:0] SUB_LOGIC_SREG  = 5'd17;
	localparam logic [SUB_W-1:0] SUB_ADDSUB_EXT  = 5'd18;
	localparam logic [SUB_W-1:0] SUB_ADDSUB_SREG = 5'd19;
	localparam logic [SUB_W-1:0] SUB_ADDSUB_CARRY = 5'd20;
	localparam logic [SUB_W-1:0] SUB_COND_CMP    = 5'd21;
	localparam logic [SUB_W-1:0] SUB_COND_SEL    = 5'd22;
	localparam logic [SUB_W-1:0] SUB_DP_1SRC     = 5'd23;
	localparam logic [SUB_W-1:0] SUB_DP_2SRC     = 5'd24;
	localparam logic [SUB_W-1:0] SUB_DP_3SRC     = 5'd25;
	localparam logic [SUB_W-1:0] SUB_NONE        = 5'd26;

	// load/store form codes
	localparam logic [FORM_W-1:0] FORM_EXCL        = 5'd0;
	localparam logic [FORM_W-1:0] FORM_LITERAL     = 5'd1;
	localparam logic [FORM_W-1:0] FORM_SIMD_MULT   = 5'd2;
	localparam logic [FORM_W-1:0] FORM_SIMD_SINGLE = 5'd3;
	localparam logic [FORM_W-1:0] FORM_UNSCALED    = 5'd4;
	localparam logic [FORM_W-1:0] FORM_UNPRIV      = 5'd5;
	localparam logic [FORM_W-1:0] FORM_POST        = 5'd6;
	localparam logic [FORM_W-1:0] FORM_PRE         = 5'd7;
	localparam logic [FORM_W-1:0] FORM_REG_OFF     = 5'd8;
	localparam logic [FORM_W-1:0] FORM_UIMM        = 5'd9;
	localparam logic [FORM_W-1:0] FORM_SIMD_REG    = 5'd10;
	localparam logic [FORM_W-1:0] FORM_PAIR_NA     = 5'd11;
	localparam logic [FORM_W-1:0] FORM_PAIR_POST   = 5'd12;
	localparam logic [FORM_W-1:0] FORM_PAIR_PRE    = 5'd13;
	localparam logic [FORM_W-1:0] FORM_PAIR_OFF    = 5'd14;
	localparam logic [FORM_W-1:0] FORM_PAIR_SIMD   = 5'd15;
	localparam logic [FORM_W-1:0] FORM_NONE        = 5'd16;

	// one classified request as it travels from front to back
	typedef struct packed {
		logic              req_type;
		logic [TOP_W-1:0]  top;
		logic [SUB_W-1:0]  sub;
		logic [FORM_W-1:0] form;
		logic [IDX_W-1:0]  idx;
	} aicp_entry_t;

endpackage

@@ hw/rtl/aicp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_front
// Accepts requests and walks the A64 decode tree for classify requests.
// ----------------------------------------------------------------------------
module aicp_front
	import aicp_pkg::*;
(
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [INSN_W-1:0] insn_word,
	input  logic [IDX_W-1:0]  counter_index,
	output logic              push,
	input  logic              q_full,
	output aicp_entry_t       push_entry
);

	// data processing, immediate
	function automatic logic [SUB_W-1:0] sub_dp_imm(input logic [INSN_W-1:0] w);
		logic [SUB_W-1:0] s;
		unique case (w[28:23])
			6'h20, 6'h21: s = SUB_PC_REL;
			6'h22, 6'h23: s = SUB_ADDSUB_IMM;
			6'h24:        s = SUB_LOGIC_IMM;
			6'h25:        s = SUB_MOVE_WIDE;
			6'h26:        s = SUB_BITFIELD;
			6'h27:        s = SUB_EXTRACT;
			default:      s = SUB_NONE;
		endcase
		return s;
	endfunction

	// system instructions
	function automatic logic [SUB_W-1:0] sub_sys(input logic [INSN_W-1:0] w);
		logic [SUB_W-1:0] s;
		s = SUB_NONE;
		priority if (w[20:19] != 2'd0) begin
			s = SUB_SYS_OTHER;
		end else if (w[21] || (w[4:0] != 5'd31)) begin
			s = SUB_NONE;
		end else begin
			unique case (w[15:12])
				4'd2:    s = SUB_SYS_HINT;
				4'd3:    s = SUB_SYS_BARRIER;
				4'd4:    s = SUB_SYS_MSR_IMM;
				default: s = SUB_NONE;
			endcase
		end
		return s;
	endfunction

	// branches, exceptions, system
	function automatic logic [SUB_W-1:0] sub_branch(input logic [INSN_W-1:0] w);
		logic [SUB_W-1:0] s;
		unique case (w[31:25])
			7'h0a, 7'h0b, 7'h4a, 7'h4b: s = SUB_UNCOND_IMM;
			7'h1a, 7'h5a:               s = SUB_CMP_BRANCH;
			7'h1b, 7'h5b:               s = SUB_TST_BRANCH;
			7'h2a:                      s = SUB_COND_BRANCH;
			7'h6a:                      s = w[24] ? sub_sys(w) : SUB_EXCEPTION;
			7'h6b:                      s = SUB_UNCOND_REG;
			default:                    s = SUB_NONE;
		endcase
		return s;
	endfunction

	// data processing, register
	function automatic logic [SUB_W-1:0] sub_dp_reg(input logic [INSN_W-1:0] w);
		logic [SUB_W-1:0] s;
		unique case (w[28:24])
			5'h0a: s = SUB_LOGIC_SREG;
			5'h0b: s = w[21] ? SUB_ADDSUB_EXT : SUB_ADDSUB_SREG;
			5'h1b: s = SUB_DP_3SRC;
			5'h1a: begin
				unique case (w[23:21])
					3'd0:    s = SUB_ADDSUB_CARRY;
					3'd2:    s = SUB_COND_CMP;
					3'd4:    s = SUB_COND_SEL;
					3'd6:    s = w[30] ? SUB_DP_1SRC : SUB_DP_2SRC;
					default: s = SUB_NONE;
				endcase
			end
			default: s = SUB_NONE;
		endcase
		return s;
	endfunction

	// load/store form
	function automatic logic [FORM_W-1:0] ldst_kind(input logic [INSN_W-1:0] w);
		logic [FORM_W-1:0] f;
		unique case (w[29:24])
			6'h08:        f = FORM_EXCL;
			6'h18, 6'h1c: f = FORM_LITERAL;
			6'h0c:        f = FORM_SIMD_MULT;
			6'h0d:        f = FORM_SIMD_SINGLE;
			6'h28, 6'h29, 6'h2c, 6'h2d: begin
				if (w[26]) begin
					f = FORM_PAIR_SIMD;
				end else begin
					unique case (w[24:23])
						2'd0: f = FORM_PAIR_NA;
						2'd1: f = FORM_PAIR_POST;
						2'd2: f = FORM_PAIR_OFF;
						2'd3: f = FORM_PAIR_PRE;
					endcase
				end
			end
			6'h38, 6'h39, 6'h3c, 6'h3d: begin
				unique case (w[25:24])
					2'd0: begin
						priority if (w[21] && (w[11:10] == 2'd2)) begin
							f = FORM_REG_OFF;
						end else if (w[26]) begin
							f = FORM_SIMD_REG;
						end else begin
							unique case (w[11:10])
								2'd0: f = FORM_UNSCALED;
								2'd1: f = FORM_POST;
								2'd2: f = FORM_UNPRIV;
								2'd3: f = FORM_PRE;
							endcase
						end
					end
					2'd1:    f = FORM_UIMM;
					default: f = FORM_NONE;
				endcase
			end
			default: f = FORM_NONE;
		endcase
		return f;
	endfunction

	// handshake into the queue
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// top-level decode
	always_comb begin
		push_entry.req_type = req_type;
		push_entry.idx      = counter_index;
		push_entry.top      = TOP_UNALLOC;
		push_entry.sub      = SUB_NONE;
		push_entry.form     = FORM_NONE;
		unique case (insn_word[28:25])
			4'h8, 4'h9: begin
				push_entry.top = TOP_DP_IMM;
				push_entry.sub = sub_dp_imm(insn_word);
			end
			4'ha, 4'hb: begin
				push_entry.top = TOP_BRANCH;
				push_entry.sub = sub_branch(insn_word);
			end
			4'h4, 4'h6, 4'hc, 4'he: begin
				push_entry.top  = TOP_LDST;
				push_entry.sub  = SUB_LDST;
				push_entry.form = ldst_kind(insn_word);
			end
			4'h5, 4'hd: begin
				push_entry.top = TOP_DP_REG;
				push_entry.sub = sub_dp_reg(insn_word);
			end
			4'h7, 4'hf: begin
				push_entry.top = TOP_SIMD_FP;
			end
			default: begin
				push_entry.top = TOP_UNALLOC;
			end
		endcase
	end

endmodule

@@ hw/rtl/aicp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_queue
// Short register queue that decouples the decode front from the counter back.
// ----------------------------------------------------------------------------
module aicp_queue
	import aicp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  aicp_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        q_valid,
	output aicp_entry_t pop_entry
);

	aicp_entry_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign q_valid   = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/aicp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_back
// Histogram counters, counter read mux and the result register.
// ----------------------------------------------------------------------------
module aicp_back
	import aicp_pkg::*;
#(
	parameter int COUNT_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  aicp_entry_t        pop_entry,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TOP_W-1:0]   top_class,
	output logic [SUB_W-1:0]   sub_class,
	output logic [FORM_W-1:0]  ldst_form,
	output logic [VALUE_W-1:0] count_value
);

	logic [COUNT_WIDTH-1:0] top_cnt_q  [N_TOP];
	logic [COUNT_WIDTH-1:0] sub_cnt_q  [N_SUB];
	logic [COUNT_WIDTH-1:0] ldst_cnt_q [N_LDST];

	logic                   out_valid_q;
	logic [TOP_W-1:0]       top_q;
	logic [SUB_W-1:0]       sub_q;
	logic [FORM_W-1:0]      form_q;
	logic [VALUE_W-1:0]     value_q;

	logic                   count_en;
	logic [IDX_W-1:0]       sub_off;
	logic [IDX_W-1:0]       ldst_off;
	logic [COUNT_WIDTH-1:0] read_val;
	logic [63:0]            read_ext;

	// take the next request when the result register is free or draining
	assign pop      = q_valid && (!out_valid_q || out_ready);
	assign count_en = pop && (pop_entry.req_type == REQ_CLASSIFY);

	// counter read mux
	assign sub_off  = pop_entry.idx - SUB_BASE;
	assign ldst_off = pop_entry.idx - LDST_BASE;
	always_comb begin
		priority if (pop_entry.idx < SUB_BASE) begin
			read_val = top_cnt_q[pop_entry.idx[TOP_W-1:0]];
		end else if (pop_entry.idx < LDST_BASE) begin
			read_val = sub_cnt_q[sub_off[SUB_W-1:0]];
		end else if (pop_entry.idx < IDX_END) begin
			read_val = ldst_cnt_q[ldst_off[FORM_W-1:0]];
		end else begin
			read_val = '0;
		end
	end
	assign read_ext = 64'(read_val);

	// histogram counters, wrap at their width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_TOP; i++) begin
				top_cnt_q[i] <= '0;
			end
			for (int i = 0; i < N_SUB; i++) begin
				sub_cnt_q[i] <= '0;
			end
			for (int i = 0; i < N_LDST; i++) begin
				ldst_cnt_q[i] <= '0;
			end
		end else if (count_en) begin
			for (int i = 0; i < N_TOP; i++) begin
				if (pop_entry.top == TOP_W'(i)) begin
					top_cnt_q[i] <= top_cnt_q[i] + 1'b1;
				end
			end
			for (int i = 0; i < N_SUB; i++) begin
				if (pop_entry.sub == SUB_W'(i)) begin
					sub_cnt_q[i] <= sub_cnt_q[i] + 1'b1;
				end
			end
			for (int i = 0; i < N_LDST; i++) begin
				if ((pop_entry.top == TOP_LDST) && (pop_entry.form == FORM_W'(i))) begin
					ldst_cnt_q[i] <= ldst_cnt_q[i] + 1'b1;
				end
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_entry.req_type == REQ_READ) begin
				top_q   <= '0;
				sub_q   <= '0;
				form_q  <= '0;
				value_q <= read_ext[VALUE_W-1:0];
			end else begin
				top_q   <= pop_entry.top;
				sub_q   <= pop_entry.sub;
				form_q  <= pop_entry.form;
				value_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign top_class   = top_q;
	assign sub_class   = sub_q;
	assign ldst_form   = form_q;
	assign count_value = value_q;

endmodule

@@ hw/rtl/a64_instruction_class_profiler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64_instruction_class_profiler
// A64 instruction class histogram: decode front, short queue, counter back.
// ----------------------------------------------------------------------------
// channel  handshake             payload
// in       in_valid / in_ready   req_type, insn_word, counter_index
// out      out_valid / out_ready top_class, sub_class, ldst_form, count_value
//
// one request per cycle sustained while out_ready stays high; a request is
// decoded into the queue when it is taken, then its counter update and
// result go into the result register, from which the result is taken at
// out_ready. reset clears all counters, the queue and the result valid flag.
// a stalled output fills the two-entry queue, after which in_ready drops.
// ----------------------------------------------------------------------------
module a64_instruction_class_profiler
	import aicp_pkg::*;
#(
	parameter int COUNT_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [INSN_W-1:0]  insn_word,
	input  logic [IDX_W-1:0]   counter_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TOP_W-1:0]   top_class,
	output logic [SUB_W-1:0]   sub_class,
	output logic [FORM_W-1:0]  ldst_form,
	output logic [VALUE_W-1:0] count_value
);

	logic        push;
	logic        q_full;
	logic        q_valid;
	logic        pop;
	aicp_entry_t push_entry;
	aicp_entry_t pop_entry;

	// decode front
	aicp_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.insn_word     (insn_word),
		.counter_index (counter_index),
		.push          (push),
		.q_full        (q_full),
		.push_entry    (push_entry)
	);

	// decoupling queue
	aicp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.pop_entry  (pop_entry)
	);

	// counter back
	aicp_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.pop_entry   (pop_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.top_class   (top_class),
		.sub_class   (sub_class),
		.ldst_form   (ldst_form),
		.count_value (count_value)
	);

`ifndef SYNTHESIS
	// an accepted request is queued on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> q_valid)
		else $error("accepted request missing from queue");

	// a popped request always produces a result on the next cycle
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("popped request produced no result");

	// a nonzero count only comes with a read result
	a_read_zero_class: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (count_value != '0)) |->
		((top_class == '0) && (sub_class == '0) && (ldst_form == '0)))
		else $error("read result carries class fields");

	// load/store top group always carries the load/store subgroup
	a_ldst_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (top_class == TOP_LDST)) |-> (sub_class == SUB_LDST))
		else $error("load/store group with wrong subgroup");
`endif

endmodule

@@ bench/a64_instruction_class_profiler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64_instruction_class_profiler_tb
// Self-checking bench for the A64 instruction class histogram. A short table
// of directed requests covers the edge cases, then random instruction words
// shaped toward most decode groups are sent, mixed with counter reads. Typed
// rows carry a fixed expectation, the rest are predicted by a local decoder
// and histogram copy, all checked in order. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module a64_instruction_class_profiler_tb;
	import aicp_pkg::*;

	typedef struct packed {
		logic              rt;
		logic [INSN_W-1:0] word;
		logic [IDX_W-1:0]  idx;
	} request_t;

	typedef struct packed {
		logic [TOP_W-1:0]   top;
		logic [SUB_W-1:0]   sub;
		logic [FORM_W-1:0]  form;
		logic [VALUE_W-1:0] value;
	} result_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		result_t  res;
	} dir_row_t;

	// opcode fields that steer the random words into the branch, register and load/store groups
	localparam logic [6:0] BRANCH_OPS [11] = '{7'h0a, 7'h0b, 7'h4a, 7'h4b, 7'h1a, 7'h5a,
		7'h1b, 7'h5b, 7'h2a, 7'h6a, 7'h6b};
	localparam logic [4:0] DPREG_OPS [4] = '{5'h0a, 5'h0b, 5'h1a, 5'h1b};
	localparam logic [5:0] LDST_OPS [15] = '{6'h08, 6'h18, 6'h1c, 6'h0c, 6'h0d, 6'h28,
		6'h29, 6'h2c, 6'h2d, 6'h38, 6'h39, 6'h3c, 6'h3d, 6'h09, 6'h3a};

	localparam int N_RANDOM = 500;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [INSN_W-1:0]  insn_word;
	logic [IDX_W-1:0]   counter_index;
	logic               out_valid;
	logic               out_ready;
	logic [TOP_W-1:0]   top_class;
	logic [SUB_W-1:0]   sub_class;
	logic [FORM_W-1:0]  ldst_form;
	logic [VALUE_W-1:0] count_value;

	// local copy of the histograms
	logic [VALUE_W-1:0] top_hist [N_TOP];
	logic [VALUE_W-1:0] sub_hist [N_SUB];
	logic [VALUE_W-1:0] ldst_hist [N_LDST];

	result_t pending_results [$];
	int      errors = 0;
	bit      calm = 1'b0;

	// directed requests: typed rows carry an expectation read off by eye
	dir_row_t dir_rows [26] = '{
		'{'{REQ_READ, 32'h0000_0000, 6'd0}, 1'b1, '0},
		'{'{REQ_READ, 32'hffff_ffff, 6'd63}, 1'b1, '0},
		'{'{REQ_READ, 32'h0000_0000, 6'd50}, 1'b1, '0},
		'{'{REQ_CLASSIFY, 32'h0000_0000, 6'd63}, 1'b1,
			'{TOP_UNALLOC, SUB_NONE, FORM_NONE, 48'd0}},
		'{'{REQ_CLASSIFY, 32'hffff_ffff, 6'd0}, 1'b1,
			'{TOP_SIMD_FP, SUB_NONE, FORM_NONE, 48'd0}},
		'{'{REQ_READ, 32'h0000_0000, 6'd5}, 1'b1, '{'0, '0, '0, 48'd1}},
		'{'{REQ_READ, 32'h0000_0000, 6'd32}, 1'b1, '{'0, '0, '0, 48'd2}},
		'{'{REQ_READ, 32'h0000_0000, 6'd49}, 1'b1, '0},
		'{'{REQ_CLASSIFY, 32'h2800_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h2880_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h2900_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h2980_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h2c00_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h0900_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_READ, 32'h0000_0000, 6'd49}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h0800_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h1800_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h3820_0800, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h3c00_0400, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h3800_0800, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'hd503_201f, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'hd400_0001, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h1b00_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_CLASSIFY, 32'h1000_0000, 6'd0}, 1'b0, '0},
		'{'{REQ_READ, 32'h0000_0000, 6'd2}, 1'b0, '0},
		'{'{REQ_READ, 32'h0000_0000, 6'd22}, 1'b0, '0}
	};

	a64_instruction_class_profiler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.insn_word     (insn_word),
		.counter_index (counter_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.top_class     (top_class),
		.sub_class     (sub_class),
		.ldst_form     (ldst_form),
		.count_value   (count_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// data-processing immediate subgroups
	function automatic logic [SUB_W-1:0] dp_imm_group(input logic [INSN_W-1:0] w);
		case (w[28:23])
			6'h20, 6'h21: return SUB_PC_REL;
			6'h22, 6'h23: return SUB_ADDSUB_IMM;
			6'h24: return SUB_LOGIC_IMM;
			6'h25: return SUB_MOVE_WIDE;
			6'h26: return SUB_BITFIELD;
			6'h27: return SUB_EXTRACT;
			default: return SUB_NONE;
		endcase
	endfunction

	// system space under the branch group
	function automatic logic [SUB_W-1:0] system_group(input logic [INSN_W-1:0] w);
		if (w[20:19] != 2'd0)
			return SUB_SYS_OTHER;
		if (w[21] || w[4:0] != 5'h1f)
			return SUB_NONE;
		case (w[15:12])
			4'd2: return SUB_SYS_HINT;
			4'd3: return SUB_SYS_BARRIER;
			4'd4: return SUB_SYS_MSR_IMM;
			default: return SUB_NONE;
		endcase
	endfunction

	function automatic logic [SUB_W-1:0] branch_group(input logic [INSN_W-1:0] w);
		case (w[31:25])
			7'h0a, 7'h0b, 7'h4a, 7'h4b: return SUB_UNCOND_IMM;
			7'h1a, 7'h5a: return SUB_CMP_BRANCH;
			7'h1b, 7'h5b: return SUB_TST_BRANCH;
			7'h2a: return SUB_COND_BRANCH;
			7'h6a: return w[24] ? system_group(w) : SUB_EXCEPTION;
			7'h6b: return SUB_UNCOND_REG;
			default: return SUB_NONE;
		endcase
	endfunction

	function automatic logic [SUB_W-1:0] dp_reg_group(input logic [INSN_W-1:0] w);
		case (w[28:24])
			5'h0a: return SUB_LOGIC_SREG;
			5'h0b: return w[21] ? SUB_ADDSUB_EXT : SUB_ADDSUB_SREG;
			5'h1b: return SUB_DP_3SRC;
			5'h1a: begin
				case (w[23:21])
					3'd0: return SUB_ADDSUB_CARRY;
					3'd2: return SUB_COND_CMP;
					3'd4: return SUB_COND_SEL;
					3'd6: return w[30] ? SUB_DP_1SRC : SUB_DP_2SRC;
					default: return SUB_NONE;
				endcase
			end
			default: return SUB_NONE;
		endcase
	endfunction

	// addressing form of a load or store
	function automatic logic [FORM_W-1:0] ldst_group(input logic [INSN_W-1:0] w);
		case (w[29:24])
			6'h08: return FORM_EXCL;
			6'h18, 6'h1c: return FORM_LITERAL;
			6'h0c: return FORM_SIMD_MULT;
			6'h0d: return FORM_SIMD_SINGLE;
			6'h28, 6'h29, 6'h2c, 6'h2d: begin
				if (w[26])
					return FORM_PAIR_SIMD;
				case (w[24:23])
					2'd0: return FORM_PAIR_NA;
					2'd1: return FORM_PAIR_POST;
					2'd2: return FORM_PAIR_OFF;
					default: return FORM_PAIR_PRE;
				endcase
			end
			6'h38, 6'h39, 6'h3c, 6'h3d: begin
				if (w[25:24] == 2'd1)
					return FORM_UIMM;
				if (w[25:24] != 2'd0)
					return FORM_NONE;
				if (w[21] && w[11:10] == 2'd2)
					return FORM_REG_OFF;
				if (w[26])
					return FORM_SIMD_REG;
				case (w[11:10])
					2'd0: return FORM_UNSCALED;
					2'd1: return FORM_POST;
					2'd2: return FORM_UNPRIV;
					default: return FORM_PRE;
				endcase
			end
			default: return FORM_NONE;
		endcase
	endfunction

	// predict one request and update the local histograms
	function automatic result_t profile_request(input request_t r);
		result_t res;
		res = '0;
		if (r.rt == REQ_READ) begin
			if (r.idx < SUB_BASE)
				res.value = top_hist[r.idx];
			else if (r.idx < LDST_BASE)
				res.value = sub_hist[r.idx - SUB_BASE];
			else if (r.idx < IDX_END)
				res.value = ldst_hist[r.idx - LDST_BASE];
			return res;
		end
		res.top = TOP_UNALLOC;
		res.sub = SUB_NONE;
		res.form = FORM_NONE;
		case (r.word[28:25])
			4'h8, 4'h9: begin
				res.top = TOP_DP_IMM;
				res.sub = dp_imm_group(r.word);
			end
			4'ha, 4'hb: begin
				res.top = TOP_BRANCH;
				res.sub = branch_group(r.word);
			end
			4'h4, 4'h6, 4'hc, 4'he: begin
				res.top = TOP_LDST;
				res.sub = SUB_LDST;
				res.form = ldst_group(r.word);
			end
			4'h5, 4'hd: begin
				res.top = TOP_DP_REG;
				res.sub = dp_reg_group(r.word);
			end
			4'h7, 4'hf: res.top = TOP_SIMD_FP;
			default: ;
		endcase
		// counters wrap at their width by plain overflow
		top_hist[res.top] = top_hist[res.top] + 1'b1;
		sub_hist[res.sub] = sub_hist[res.sub] + 1'b1;
		if (res.top == TOP_LDST)
			ldst_hist[res.form] = ldst_hist[res.form] + 1'b1;
		return res;
	endfunction

	// random word, usually forced into one decode group
	function automatic logic [INSN_W-1:0] random_insn();
		logic [INSN_W-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 6))
			0: w[28:23] = 6'h20 | 6'($urandom_range(0, 7));
			1: w[31:25] = BRANCH_OPS[$urandom_range(0, 10)];
			2: begin
				w[31:24] = 8'hd5;
				w[20:19] = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd0;
				w[21] = ($urandom_range(0, 5) == 0);
				w[4:0] = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'h1f;
				w[15:12] = 4'($urandom_range(1, 5));
			end
			3: w[28:24] = DPREG_OPS[$urandom_range(0, 3)];
			4, 5: begin
				w[29:24] = LDST_OPS[$urandom_range(0, 14)];
				if ($urandom_range(0, 2) == 0) begin
					w[21] = 1'b1;
					w[11:10] = 2'd2;
				end
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic int draw_gap();
		if (calm)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// present one request and hold it until taken
	task automatic send_request(input request_t r, input logic typed, input result_t typed_res);
		int      gap;
		result_t predicted;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.rt;
		insn_word <= r.word;
		counter_index <= r.idx;
		do @(posedge clk); while (!in_ready);
		predicted = profile_request(r);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic check_result();
		result_t want;
		result_t got;
		got = '{top_class, sub_class, ldst_form, count_value};
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: top %0d sub %0d form %0d value %0d",
					got.top, got.sub, got.form, got.value);
			return;
		end
		want = pending_results.pop_front();
		if (got != want) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: exp top %0d sub %0d form %0d value %0d, got top %0d sub %0d form %0d value %0d",
					want.top, want.sub, want.form, want.value,
					got.top, got.sub, got.form, got.value);
		end
	endtask

	// request side
	initial begin
		request_t r;
		int       n;
		for (int i = 0; i < N_TOP; i++) top_hist[i] = '0;
		for (int i = 0; i < N_SUB; i++) sub_hist[i] = '0;
		for (int i = 0; i < N_LDST; i++) ldst_hist[i] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_CLASSIFY;
		insn_word <= '0;
		counter_index <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
		for (n = 0; n < N_RANDOM; n++) begin
			// switch between stalling and back-to-back stretches
			if (n % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r.rt = ($urandom_range(0, 3) == 0) ? REQ_READ : REQ_CLASSIFY;
			r.word = random_insn();
			r.idx = 6'($urandom_range(0, 63));
			send_request(r, 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("a64_instruction_class_profiler_tb passed");
		else
			$display("a64_instruction_class_profiler_tb failed");
		$finish;
	end

	// result side
	initial begin
		int gap;
		out_ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_result();
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("a64_instruction_class_profiler_tb failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/aicp_pkg.sv
hw/rtl/aicp_front.sv
hw/rtl/aicp_queue.sv
hw/rtl/aicp_back.sv
hw/rtl/a64_instruction_class_profiler.sv
bench/a64_instruction_class_profiler_tb.sv
